// File: design/mner_pkg.sv
// shared types, codes and tone tables of the note event recorder
`timescale 1ns / 1ps
`default_nettype none
package mner_pkg;

    localparam int LIST_DEPTH_DEF = 256;
    localparam int KEY_SLOTS      = 128;

    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_APPEND = 2'd1;
    localparam logic [1:0] WR_FILLED = 2'd2;

    localparam logic CFG_REC       = 1'b0;
    localparam logic CFG_TRANSPOSE = 1'b1;

    localparam logic [8:0] TONE_LO   = 9'd60;
    localparam logic [8:0] TONE_HI   = 9'd83;
    localparam logic [8:0] KEY_SHIFT = 9'd12;

    typedef struct packed {
        logic load;
        logic exec_clear;
        logic exec_on;
        logic exec_other;
        logic rd_start;
        logic chk_off;
        logic rd_list;
        logic cmp_list;
        logic post;
    } cmd_t;

    typedef struct packed {
        logic is_clear;
        logic is_on;
        logic is_off;
        logic begin_zero;
        logic total_zero;
        logic match;
        logic idx_zero;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [8:0] recorded_count;
        logic [7:0] entry_duration;
        logic [7:0] entry_index;
        logic [1:0] entry_written;
        logic [7:0] pwm_period;
        logic [9:0] tone_frequency;
        logic [1:0] tone_action;
    } result_t;

    function automatic logic [9:0] tone_freq(input logic [4:0] i);
        logic [9:0] f;
        case (i)
            5'd0:  f = 10'd262;
            5'd1:  f = 10'd277;
            5'd2:  f = 10'd294;
            5'd3:  f = 10'd311;
            5'd4:  f = 10'd330;
            5'd5:  f = 10'd349;
            5'd6:  f = 10'd370;
            5'd7:  f = 10'd392;
            5'd8:  f = 10'd415;
            5'd9:  f = 10'd440;
            5'd10: f = 10'd466;
            5'd11: f = 10'd494;
            5'd12: f = 10'd523;
            5'd13: f = 10'd554;
            5'd14: f = 10'd587;
            5'd15: f = 10'd622;
            5'd16: f = 10'd659;
            5'd17: f = 10'd698;
            5'd18: f = 10'd740;
            5'd19: f = 10'd784;
            5'd20: f = 10'd831;
            5'd21: f = 10'd880;
            5'd22: f = 10'd932;
            5'd23: f = 10'd988;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

    // 62500 / (2 * f), precomputed
    function automatic logic [7:0] tone_period(input logic [4:0] i);
        logic [7:0] p;
        case (i)
            5'd0:  p = 8'd119;
            5'd1:  p = 8'd112;
            5'd2:  p = 8'd106;
            5'd3:  p = 8'd100;
            5'd4:  p = 8'd94;
            5'd5:  p = 8'd89;
            5'd6:  p = 8'd84;
            5'd7:  p = 8'd79;
            5'd8:  p = 8'd75;
            5'd9:  p = 8'd71;
            5'd10: p = 8'd67;
            5'd11: p = 8'd63;
            5'd12: p = 8'd59;
            5'd13: p = 8'd56;
            5'd14: p = 8'd53;
            5'd15: p = 8'd50;
            5'd16: p = 8'd47;
            5'd17: p = 8'd44;
            5'd18: p = 8'd42;
            5'd19: p = 8'd39;
            5'd20: p = 8'd37;
            5'd21: p = 8'd35;
            5'd22: p = 8'd33;
            5'd23: p = 8'd31;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// File: design/midi_note_event_recorder_unit.sv
// top level of the midi note event recorder
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata (message), s_tuser (clear request)
// m_       out  m_tvalid/m_tready  m_tdata (result)
// cfg_     in   cfg_we             cfg_index, cfg_data
//
// clear, note-on and other messages pass through EXEC and FIN to the result;
// a note-off also checks the start table, then reads and compares list entries
// in turn (up to LIST_DEPTH entries), set by the single read port of the list memory
// rst_n clears the start-table valid bits, list count and output flag at once
// a waiting result does not block the next request; a second result waits
// in the controller until the output register frees
`timescale 1ns / 1ps
`default_nettype none
module midi_note_event_recorder_unit #(
    parameter int LIST_DEPTH = mner_pkg::LIST_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,   // 0 recording_enabled, 1 transpose_steps
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // status_byte[7:0], key_number[14:8], velocity[21:15], timestamp[37:22]
    input  wire logic [39:0] s_tdata,
    input  wire logic        s_tuser,     // clear_all
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tone_action[1:0], tone_frequency[11:2], pwm_period[19:12],
    // entry_written[21:20], entry_index[29:22], entry_duration[37:30],
    // recorded_count[46:38]
    output logic [47:0]      m_tdata
);
    import mner_pkg::*;

    cmd_t    cmd;
    sts_t    sts;
    result_t res;
    logic    in_fire;

    // a request is taken only when the controller is idle
    assign in_fire = s_tvalid && s_tready;
    assign m_tdata = {1'b0, res};

    mner_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    mner_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_clear  (s_tuser),
        .in_data   (s_tdata[37:0]),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

`ifndef SYNTH
    // one request at a time: none taken right after another
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("request taken while busy");

    // no list write without a tone action
    a_wr_act: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ACT_NONE)) |-> (m_tdata[21:20] == WR_NONE))
        else $error("entry written without tone action");

    // an append only comes with a start tone; fills are not checked here
    a_wr_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[21:20] == WR_APPEND)) |-> (m_tdata[1:0] == ACT_START))
        else $error("append without start tone");

    // count never passes the list depth
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({23'd0, m_tdata[46:38]} <= 32'(LIST_DEPTH)))
        else $error("recorded count beyond list depth");
`endif

endmodule
`default_nettype wire

// File: design/mner_ctrl.sv
// controller state machine of the note event recorder
`timescale 1ns / 1ps
`default_nettype none
module mner_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire mner_pkg::sts_t sts,
    output logic               in_ready,
    output mner_pkg::cmd_t     cmd
);
    import mner_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_LRD  = 3'd3;
    localparam logic [2:0] S_LCMP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.is_clear)
                begin
                    cmd.exec_clear = 1'b1;
                    state_next     = S_FIN;
                end
                else if (sts.is_on)
                begin
                    cmd.exec_on = 1'b1;
                    state_next  = S_FIN;
                end
                else if (sts.is_off)
                begin
                    cmd.rd_start = 1'b1;
                    state_next   = S_CHK;
                end
                else
                begin
                    cmd.exec_other = 1'b1;
                    state_next     = S_FIN;
                end
            end
            S_CHK:
            begin
                cmd.chk_off = 1'b1;
                if (sts.begin_zero || sts.total_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LRD;
                end
            end
            S_LRD:
            begin
                cmd.rd_list = 1'b1;
                state_next  = S_LCMP;
            end
            S_LCMP:
            begin
                cmd.cmp_list = 1'b1;
                if (sts.match || sts.idx_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_LRD;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/mner_dp.sv
// datapath of the note event recorder: tables, list memory, result registers
`timescale 1ns / 1ps
`default_nettype none
module mner_dp #(
    parameter int LIST_DEPTH = mner_pkg::LIST_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [7:0]      cfg_data,
    input  wire logic            in_clear,
    input  wire logic [37:0]     in_data,
    input  wire logic            out_ready,
    input  wire mner_pkg::cmd_t  cmd,
    output mner_pkg::sts_t       sts,
    output logic                 out_valid,
    output mner_pkg::result_t    out_res
);
    import mner_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic        rec_reg;
    logic [7:0]  tr_reg;
    logic        clr_reg;
    logic [3:0]  op_reg;
    logic [6:0]  key_reg;
    logic [6:0]  vel_reg;
    logic [15:0] ts_reg;

    logic [15:0]        st_mem [KEY_SLOTS];
    logic [KEY_SLOTS-1:0] st_vld_reg;
    logic [15:0]        st_rd_reg;
    logic               st_rd_vld_reg;

    // list word: {length, note}
    logic [14:0]   list_mem [LIST_DEPTH];
    logic [14:0]   lm_rd_reg;
    logic [CW-1:0] total_reg;
    logic [IW-1:0] idx_reg;
    logic [7:0]    elapsed_reg;

    result_t res_reg;
    result_t res_next;
    result_t out_reg;
    logic    out_vld_reg;

    logic [CW-1:0] total_inc;
    logic [CW-1:0] total_dec;
    logic          list_full;
    logic [8:0]    tone_sum;
    logic          tone_ok;
    logic [8:0]    tone_off;
    logic [15:0]   begin_t;
    logic          is_on;
    logic [IW-1:0] app_idx;

    assign total_inc = total_reg + 1'b1;
    assign total_dec = total_reg - 1'b1;
    assign app_idx   = total_reg[IW-1:0];
    assign list_full = (total_reg == CW'(LIST_DEPTH));
    assign tone_sum  = {2'b00, key_reg} + KEY_SHIFT + {1'b0, tr_reg};
    assign tone_ok   = (tone_sum >= TONE_LO) && (tone_sum <= TONE_HI);
    assign tone_off  = tone_sum - TONE_LO;
    assign begin_t   = st_rd_vld_reg ? st_rd_reg : 16'd0;
    assign is_on     = (op_reg == CMD_NOTE_ON) && (vel_reg != 7'd0);

    assign sts.is_clear   = clr_reg;
    assign sts.is_on      = is_on;
    assign sts.is_off     = (op_reg == CMD_NOTE_OFF) || (op_reg == CMD_NOTE_ON);
    assign sts.begin_zero = (begin_t == 16'd0);
    assign sts.total_zero = (total_reg == '0);
    assign sts.match      = (lm_rd_reg[6:0] == key_reg) && (lm_rd_reg[14:7] == 8'd0);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.out_free   = !out_vld_reg || out_ready;

    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

    // configuration and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg     <= 1'b0;
            tr_reg      <= 8'd0;
            st_vld_reg  <= '0;
            total_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == CFG_REC))
            begin
                rec_reg <= cfg_data[0];
            end
            if (cfg_we && (cfg_index == CFG_TRANSPOSE))
            begin
                tr_reg <= cfg_data;
            end
            if (cmd.exec_clear)
            begin
                st_vld_reg <= '0;
                total_reg  <= '0;
            end
            if (cmd.exec_on)
            begin
                st_vld_reg[key_reg] <= 1'b1;
                if (rec_reg && !list_full)
                begin
                    total_reg <= total_inc;
                end
            end
            if (cmd.chk_off && (begin_t != 16'd0))
            begin
                st_vld_reg[key_reg] <= 1'b0;
            end
            if (cmd.post)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // start time table
    always_ff @(posedge clk)
    begin
        if (cmd.exec_on)
        begin
            st_mem[key_reg] <= ts_reg;
        end
        if (cmd.rd_start)
        begin
            st_rd_reg     <= st_mem[key_reg];
            st_rd_vld_reg <= st_vld_reg[key_reg];
        end
    end

    // melody list memory, one port shared by append and fill
    always_ff @(posedge clk)
    begin
        if (cmd.exec_on && rec_reg && !list_full)
        begin
            list_mem[app_idx] <= {8'd0, key_reg};
        end
        else if (cmd.cmp_list && sts.match)
        begin
            list_mem[idx_reg] <= {elapsed_reg, key_reg};
        end
        if (cmd.rd_list)
        begin
            lm_rd_reg <= list_mem[idx_reg];
        end
    end

    // result build-up
    always_comb
    begin
        res_next = res_reg;
        if (cmd.exec_clear)
        begin
            res_next = '0;
        end
        if (cmd.exec_other)
        begin
            res_next                = '0;
            res_next.recorded_count = 9'({9'd0, total_reg});
        end
        if (cmd.exec_on)
        begin
            res_next                = '0;
            res_next.tone_action    = ACT_START;
            res_next.tone_frequency = tone_ok ? tone_freq(tone_off[4:0]) : 10'd0;
            res_next.pwm_period     = tone_ok ? tone_period(tone_off[4:0]) : 8'd0;
            res_next.recorded_count = 9'({9'd0, total_reg});
            if (rec_reg && !list_full)
            begin
                res_next.entry_written  = WR_APPEND;
                res_next.entry_index    = 8'({8'd0, app_idx});
                res_next.recorded_count = 9'({9'd0, total_inc});
            end
        end
        if (cmd.rd_start)
        begin
            res_next                = '0;
            res_next.tone_action    = ACT_STOP;
            res_next.recorded_count = 9'({9'd0, total_reg});
        end
        if (cmd.cmp_list && sts.match)
        begin
            res_next.entry_written  = WR_FILLED;
            res_next.entry_index    = 8'({8'd0, idx_reg});
            res_next.entry_duration = elapsed_reg;
        end
    end

    // request fields, search registers and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            clr_reg <= in_clear;
            op_reg  <= in_data[7:4];
            key_reg <= in_data[14:8];
            vel_reg <= in_data[21:15];
            ts_reg  <= in_data[37:22];
        end
        res_reg <= res_next;
        if (cmd.chk_off)
        begin
            elapsed_reg <= ts_reg[7:0] - begin_t[7:0];
            idx_reg     <= total_dec[IW-1:0];
        end
        if (cmd.cmp_list && !sts.match)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.post)
        begin
            out_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire

// File: dv/mner_checker.sv
// checker for the note event recorder: watches the channels, predicts and compares results
`timescale 1ns / 1ps
module mner_checker
    import mner_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    output int          fail_count,
    output int          pending,
    output int          checked,
    output int          appended,
    output int          filled
);

    localparam int DEPTH = LIST_DEPTH_DEF;

    // own copy of the block state
    logic [15:0] key_start [KEY_SLOTS];
    logic [7:0]  mel_key   [DEPTH];
    logic [7:0]  mel_len   [DEPTH];
    int          mel_count;
    logic        rec_on;
    logic [7:0]  semitones;
    result_t     want_q [$];

    int tone_hz [24] = '{262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
                         523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988};

    function automatic result_t play_message(input logic clr, input logic [7:0] status,
                                             input logic [6:0] key, input logic [6:0] vel,
                                             input logic [15:0] stamp);
        result_t r;
        int      pos;
        int      hz;
        logic [15:0] elapsed;
        r = '0;
        if (clr) begin
            foreach (key_start[k]) key_start[k] = '0;
            mel_count = 0;
        end else if (status[7:4] == CMD_NOTE_ON && vel != 0) begin
            key_start[key] = stamp;
            if (rec_on && mel_count < DEPTH) begin
                mel_key[mel_count] = {1'b0, key};
                mel_len[mel_count] = '0;
                r.entry_written = WR_APPEND;
                r.entry_index   = mel_count[7:0];
                mel_count++;
                appended++;
            end
            pos = int'(key) + 12 + int'(semitones);
            hz  = (pos >= 60 && pos <= 83) ? tone_hz[pos - 60] : 0;
            r.tone_frequency = hz[9:0];
            r.pwm_period     = (hz != 0) ? 8'(62500 / (2 * hz)) : 8'd0;
            r.tone_action    = ACT_START;
        end else if (status[7:4] == CMD_NOTE_OFF || status[7:4] == CMD_NOTE_ON) begin
            if (key_start[key] != 0) begin
                elapsed = stamp - key_start[key];
                // newest open entry of this key wins
                for (pos = mel_count - 1; pos >= 0; pos--) begin
                    if (mel_key[pos] == {1'b0, key} && mel_len[pos] == 0) begin
                        mel_len[pos]     = elapsed[7:0];
                        r.entry_written  = WR_FILLED;
                        r.entry_index    = pos[7:0];
                        r.entry_duration = elapsed[7:0];
                        filled++;
                        break;
                    end
                end
                key_start[key] = '0;
            end
            r.tone_action = ACT_STOP;
        end
        r.recorded_count = mel_count[8:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            foreach (key_start[k]) key_start[k] = '0;
            mel_count  = 0;
            rec_on     = 1'b0;
            semitones  = '0;
            want_q     = {};
            fail_count = 0;
            pending    = 0;
            checked    = 0;
            appended   = 0;
            filled     = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_REC) rec_on = cfg_data[0];
                else semitones = cfg_data;
            end
            if (s_tvalid && s_tready)
                want_q.push_back(play_message(s_tuser, s_tdata[7:0], s_tdata[14:8],
                                              s_tdata[21:15], s_tdata[37:22]));
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[46:0]);
                if (want_q.size() == 0) begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end else begin
                    want = want_q.pop_front();
                    check_field("tone_action",    want.tone_action,    got.tone_action);
                    check_field("tone_frequency", want.tone_frequency, got.tone_frequency);
                    check_field("pwm_period",     want.pwm_period,     got.pwm_period);
                    check_field("entry_written",  want.entry_written,  got.entry_written);
                    check_field("entry_index",    want.entry_index,    got.entry_index);
                    check_field("entry_duration", want.entry_duration, got.entry_duration);
                    check_field("recorded_count", want.recorded_count, got.recorded_count);
                    checked++;
                end
            end
            pending = want_q.size();
        end
    end

endmodule

// File: dv/tb_top.sv
// testbench top of the note event recorder: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_top;
    import mner_pkg::*;

    localparam int IDLE_LIMIT = 4000;   // longer than the slowest list search and the long result hold
    localparam int PHASE_MSGS = 230;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    int fail_count, pending, checked, appended, filled;
    int sent = 0;
    int idle_cycles = 0;
    logic hold_req = 1'b0;

    // stimulus-side view of the block
    logic [15:0] now_tick = 16'd1;
    logic [7:0]  cur_transpose = '0;
    logic [6:0]  held_keys [$];

    midi_note_event_recorder_unit u_top (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    mner_checker u_checker (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .fail_count, .pending, .checked, .appended, .filled
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watchdog: cycles with no request, result or register write
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result side: short random stalls, a few long ones, and one long hold on demand
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 12)
            begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                          : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // register write, called at a rising edge, then idles before it returns
    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TRANSPOSE) cur_transpose = val;
        @(posedge clk);
    endtask

    // offer one request and wait for it to be taken, then maybe idle
    task automatic send_msg(input logic clr, input logic [7:0] status, input logic [6:0] key,
                            input logic [6:0] vel, input logic [15:0] stamp, input bit burst);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= clr;
        s_tdata  <= {2'b00, stamp, vel, key, status};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        gap = 0;
        if (!burst && $urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let every outstanding result drain
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // one message of the random part: mostly matched note-on/note-off pairs
    task automatic random_msg(input bit burst);
        int          pick;
        logic [6:0]  key;
        logic [15:0] stamp;
        int          slot;
        pick = $urandom_range(0, 999);
        now_tick = ($urandom_range(0, 29) == 0) ? 16'($urandom) :
                   now_tick + 16'($urandom_range(1, 300));
        stamp = now_tick;
        if (pick < 3)
            send_msg(1'b1, 8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), burst);
        else if (pick < 480 || held_keys.size() == 0)
        begin
            // keys around the audible window for the current transpose
            key = 7'(48 - int'(cur_transpose) + $urandom_range(0, 27) - 2);
            held_keys.push_back(key);
            send_msg(1'b0, {CMD_NOTE_ON, 4'($urandom)}, key, 7'($urandom_range(1, 127)),
                     stamp, burst);
        end
        else if (pick < 860)
        begin
            slot = $urandom_range(0, held_keys.size() - 1);
            key = held_keys[slot];
            held_keys.delete(slot);
            if ($urandom_range(0, 2) == 0)
                send_msg(1'b0, {CMD_NOTE_ON, 4'($urandom)}, key, 7'd0, stamp, burst);
            else
                send_msg(1'b0, {CMD_NOTE_OFF, 4'($urandom)}, key, 7'($urandom), stamp, burst);
        end
        else
            // noise: any status, any key, any velocity, any time
            send_msg(1'b0, 8'($urandom), 7'($urandom), 7'($urandom), 16'($urandom), burst);
    endtask

    initial
    begin
        logic [7:0] rec_set  [6] = '{8'd1, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0};
        logic [7:0] tr_set   [6] = '{8'd0, 8'd255, 8'd48, 8'd12, 8'd0, 8'd0};
        int burst_left;
        burst_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_REC, 8'd1);
        write_reg(CFG_TRANSPOSE, 8'd0);

        // directed: extremes and special cases
        send_msg(1'b0, 8'h90, 7'd0,   7'd1,   16'd0,     1'b0); // note-on at time zero
        send_msg(1'b0, 8'h80, 7'd0,   7'd0,   16'd50,    1'b0); // slot empty, only stop
        send_msg(1'b0, 8'h9F, 7'd127, 7'd127, 16'hFFFF,  1'b0); // top key, unknown note
        send_msg(1'b0, 8'h9F, 7'd127, 7'd0,   16'd9,     1'b0); // velocity 0 off, wraps
        send_msg(1'b0, 8'h90, 7'd48,  7'd64,  16'd100,   1'b0); // lowest known tone
        send_msg(1'b0, 8'h90, 7'd71,  7'd64,  16'd110,   1'b0); // highest known tone
        send_msg(1'b0, 8'h90, 7'd72,  7'd64,  16'd120,   1'b0); // just above the table
        send_msg(1'b0, 8'h90, 7'd47,  7'd64,  16'd130,   1'b0); // just below the table
        send_msg(1'b0, 8'h80, 7'd48,  7'd0,   16'd356,   1'b0); // elapsed 256: stays open
        send_msg(1'b0, 8'h90, 7'd48,  7'd10,  16'd400,   1'b0);
        send_msg(1'b0, 8'h8F, 7'd48,  7'd127, 16'd405,   1'b0); // fills newest open entry
        send_msg(1'b0, 8'h80, 7'd71,  7'd0,   16'd200,   1'b0);
        send_msg(1'b0, 8'h80, 7'd5,   7'd0,   16'd300,   1'b0); // off with no note-on
        send_msg(1'b0, 8'hF0, 7'd60,  7'd60,  16'd301,   1'b0); // other status
        send_msg(1'b0, 8'hA5, 7'd85,  7'd42,  16'hAAAA,  1'b0);
        send_msg(1'b0, 8'h7F, 7'd127, 7'd127, 16'h5555,  1'b0);
        send_msg(1'b0, 8'h90, 7'd60,  7'd1,   16'hFFF0,  1'b0);
        send_msg(1'b0, 8'h80, 7'd60,  7'd0,   16'h0010,  1'b0); // elapsed wraps
        send_msg(1'b1, 8'hFF, 7'd127, 7'd127, 16'hFFFF,  1'b0); // clear with junk fields
        send_msg(1'b0, 8'h80, 7'd72,  7'd0,   16'd20,    1'b0); // after clear: empty
        wait_drained();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_REC, rec_set[ph]);
            write_reg(CFG_TRANSPOSE, (ph == 4) ? 8'($urandom) : tr_set[ph]);
            held_keys = {};
            if (ph == 1) hold_req = 1'b1;  // fill the block while results are held
            for (int n = 0; n < PHASE_MSGS; n++)
            begin
                if (burst_left > 0) burst_left--;
                else if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
                random_msg(burst_left > 0);
            end
            wait_drained();
        end

        repeat (50) @(posedge clk);
        $display("covered %0d requests and %0d results over 7 register settings,",
                 sent, checked);
        $display("with %0d list appends and %0d durations filled", appended, filled);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
